>>> design/bfha_pkg.sv
package bfha_pkg;

  localparam int HEAP_BYTES = 4096;
  localparam int HDR_BYTES  = 16;
  localparam int ADDR_W     = $clog2(HEAP_BYTES);
  localparam int SIZE_W     = ADDR_W;
  localparam int REQ_W      = ADDR_W + 1;
  localparam int CNT_W      = 9;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NOFIT  = 3'd1,
    ST_NULL   = 3'd2,
    ST_RANGE  = 3'd3,
    ST_BADPTR = 3'd4,
    ST_DOUBLE = 3'd5
  } status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_AW_RD,
    S_AW_EV,
    S_AC_DEC,
    S_AC_RDN,
    S_AC_WN,
    S_AC_WNH,
    S_AC_WB,
    S_F_RDH,
    S_F_EVH,
    S_F_RDP,
    S_F_EVP,
    S_F_RDX,
    S_F_EVX,
    S_F_RDNN,
    S_F_EVNN,
    S_F_WK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              is_free;
    logic [SIZE_W-1:0] size;
    logic              has_prev;
    logic [ADDR_W-1:0] prev;
    logic              has_next;
    logic [ADDR_W-1:0] next;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  typedef struct packed {
    logic              op;
    logic [REQ_W-1:0]  req_size;
    logic              ptr_null;
    logic [ADDR_W-1:0] payload_offset;
  } bfha_in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] alloc_offset;
    logic [CNT_W-1:0]  live_chunks;
  } bfha_out_t;

endpackage

>>> design/bfha_ram.sv
module bfha_ram #(
  parameter int AW = 12,
  parameter int DW = 40
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/best_fit_heap_allocator_core.sv
// best-fit heap allocator, headers kept in a 4096-entry single-port-pair ram
// allocate: a read and an evaluate state per chunk in the chain walk, then a commit
// free: header, neighbor and relink reads, one ram read each
// one word in flight at a time; result held in an output register
// rst_n (sync) starts a clearing pass over every header ram entry, no word
// is accepted until it ends
module best_fit_heap_allocator_core
  import bfha_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bfha_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output bfha_out_t out_data
);

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0] clr_cnt_r;
  bfha_in_t          req_r;
  logic [ADDR_W-1:0] cur_r, best_r, keep_r, h_r, nh_r;
  logic [ADDR_W:0]   steps_r;
  logic              found_r, split_r, mergep_r;
  hdr_t              best_ent_r, eh_r, k_r;
  logic [CNT_W-1:0]  cnt_r;
  status_t           st_r;
  logic [ADDR_W-1:0] off_r;
  logic              out_valid_r;
  bfha_out_t         out_r;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  hdr_t              ram_wdata, rd;
  logic [HDR_W-1:0]  rd_bits;

  bfha_ram #(.AW(ADDR_W), .DW(HDR_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_bits)
  );
  assign rd = hdr_t'(rd_bits);

  // size compare / split arithmetic
  logic              fits, better, more, split_ok;
  logic [ADDR_W+1:0] need, nh_wide;
  logic              in_acc, out_acc;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid_r && out_ready;
  assign fits     = rd.valid && rd.is_free && ({1'b0, rd.size} >= req_r.req_size);
  assign better   = !found_r || (rd.size < best_ent_r.size);
  assign more     = rd.has_next && (steps_r < (ADDR_W+1)'(HEAP_BYTES - 1));
  assign need     = {1'b0, req_r.req_size} + (ADDR_W+2)'(HDR_BYTES);
  assign nh_wide  = {2'b0, best_r} + need;
  assign split_ok = ({2'b0, best_ent_r.size} >= need) &&
                    (nh_wide < (ADDR_W+2)'(HEAP_BYTES));

  hdr_t x_mod, k_merge_p, k_merge_x, best_wr, nh_ent, rd_freed;

  // merged and relinked header images
  always_comb begin
    x_mod = rd;
    if (mergep_r) begin
      x_mod.has_prev = 1'b1;
      x_mod.prev     = keep_r;
    end
    rd_freed           = rd;
    rd_freed.is_free   = 1'b1;
    k_merge_p          = rd;
    k_merge_p.size     = SIZE_W'(rd.size + SIZE_W'(HDR_BYTES) + eh_r.size);
    k_merge_p.has_next = eh_r.has_next;
    k_merge_p.next     = eh_r.next;
    k_merge_x          = k_r;
    k_merge_x.size     = SIZE_W'(k_r.size + SIZE_W'(HDR_BYTES) + rd.size);
    k_merge_x.has_next = rd.has_next;
    k_merge_x.next     = rd.next;
    best_wr            = best_ent_r;
    best_wr.is_free    = 1'b0;
    if (split_r) begin
      best_wr.size     = SIZE_W'(req_r.req_size);
      best_wr.has_next = 1'b1;
      best_wr.next     = nh_r;
    end
    nh_ent          = best_ent_r;
    nh_ent.valid    = 1'b1;
    nh_ent.is_free  = 1'b1;
    nh_ent.size     = SIZE_W'({2'b0, best_ent_r.size} - need);
    nh_ent.has_prev = 1'b1;
    nh_ent.prev     = best_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_cnt_r == ADDR_W'(HEAP_BYTES - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.op == OP_ALLOC) begin
            state_nxt = S_AW_RD;
          end else if (in_data.ptr_null ||
                       in_data.payload_offset < ADDR_W'(HDR_BYTES)) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_F_RDH;
          end
        end
      end
      S_AW_RD:  state_nxt = S_AW_EV;
      S_AW_EV:  state_nxt = more ? S_AW_RD : S_AC_DEC;
      S_AC_DEC: begin
        priority if (!found_r) state_nxt = S_FIN;
        else if (split_ok && best_ent_r.has_next) state_nxt = S_AC_RDN;
        else if (split_ok) state_nxt = S_AC_WNH;
        else state_nxt = S_AC_WB;
      end
      S_AC_RDN: state_nxt = S_AC_WN;
      S_AC_WN:  state_nxt = S_AC_WNH;
      S_AC_WNH: state_nxt = S_AC_WB;
      S_AC_WB:  state_nxt = S_FIN;
      S_F_RDH:  state_nxt = S_F_EVH;
      S_F_EVH: begin
        priority if (!rd.valid || rd.is_free) state_nxt = S_FIN;
        else if (rd.has_prev) state_nxt = S_F_RDP;
        else if (rd.has_next) state_nxt = S_F_RDX;
        else state_nxt = S_F_WK;
      end
      S_F_RDP:  state_nxt = S_F_EVP;
      S_F_EVP:  state_nxt = eh_r.has_next ? S_F_RDX : S_F_WK;
      S_F_RDX:  state_nxt = S_F_EVX;
      S_F_EVX:  state_nxt = (rd.valid && rd.is_free && rd.has_next) ? S_F_RDNN : S_F_WK;
      S_F_RDNN: state_nxt = S_F_EVNN;
      S_F_EVNN: state_nxt = S_F_WK;
      S_F_WK:   state_nxt = S_FIN;
      S_FIN:    if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // ram control and handshake outputs
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = keep_r;
    ram_wdata = k_r;
    ram_raddr = cur_r;
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
        if (clr_cnt_r == '0) begin
          ram_wdata.valid   = 1'b1;
          ram_wdata.is_free = 1'b1;
          ram_wdata.size    = SIZE_W'(HEAP_BYTES - HDR_BYTES);
        end
      end
      S_AC_RDN: ram_raddr = best_ent_r.next;
      S_AC_WN: begin
        ram_we        = 1'b1;
        ram_waddr     = best_ent_r.next;
        ram_wdata     = rd;
        ram_wdata.has_prev = 1'b1;
        ram_wdata.prev     = nh_r;
      end
      S_AC_WNH: begin
        ram_we    = 1'b1;
        ram_waddr = nh_r;
        ram_wdata = nh_ent;
      end
      S_AC_WB: begin
        ram_we    = 1'b1;
        ram_waddr = best_r;
        ram_wdata = best_wr;
      end
      S_F_RDH: ram_raddr = h_r;
      S_F_RDP: ram_raddr = eh_r.prev;
      S_F_EVP: begin
        // absorbed header goes invalid
        ram_we          = rd.is_free;
        ram_waddr       = h_r;
        ram_wdata       = eh_r;
        ram_wdata.valid = 1'b0;
      end
      S_F_RDX: ram_raddr = eh_r.next;
      S_F_EVX: begin
        ram_we    = mergep_r || (rd.valid && rd.is_free);
        ram_waddr = eh_r.next;
        ram_wdata = x_mod;
        if (rd.valid && rd.is_free) ram_wdata.valid = 1'b0;
      end
      S_F_RDNN: ram_raddr = k_r.next;
      S_F_EVNN: begin
        ram_we    = 1'b1;
        ram_waddr = k_r.next;
        ram_wdata = rd;
        ram_wdata.has_prev = 1'b1;
        ram_wdata.prev     = keep_r;
      end
      S_F_WK: ram_we = 1'b1;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == S_AC_WB) cnt_r <= cnt_r + 1'b1;
      if (state_r == S_F_WK && cnt_r != '0) cnt_r <= cnt_r - 1'b1;
      if (state_r == S_FIN && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        req_r    <= in_data;
        cur_r    <= '0;
        steps_r  <= '0;
        found_r  <= 1'b0;
        mergep_r <= 1'b0;
        off_r    <= '0;
        h_r      <= in_data.payload_offset - ADDR_W'(HDR_BYTES);
        st_r     <= in_data.ptr_null ? ST_NULL : ST_RANGE;
      end
      S_AW_EV: begin
        if (fits && better) begin
          best_r     <= cur_r;
          best_ent_r <= rd;
          found_r    <= 1'b1;
        end
        cur_r   <= rd.next;
        steps_r <= steps_r + 1'b1;
      end
      S_AC_DEC: begin
        split_r <= split_ok;
        nh_r    <= ADDR_W'(nh_wide);
        st_r    <= found_r ? ST_OK : ST_NOFIT;
      end
      S_AC_WB: off_r <= best_r + ADDR_W'(HDR_BYTES);
      S_F_EVH: begin
        eh_r      <= rd;
        k_r       <= rd_freed;
        keep_r    <= h_r;
        priority if (!rd.valid) st_r <= ST_BADPTR;
        else if (rd.is_free) st_r <= ST_DOUBLE;
        else st_r <= ST_OK;
      end
      S_F_EVP: begin
        if (rd.is_free) begin
          mergep_r <= 1'b1;
          keep_r   <= eh_r.prev;
          k_r      <= k_merge_p;
        end
      end
      S_F_EVX: if (rd.valid && rd.is_free) k_r <= k_merge_x;
      S_FIN: if (!out_valid_r || out_ready) begin
        out_r.status       <= st_r;
        out_r.alloc_offset <= off_r;
        out_r.live_chunks  <= cnt_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // no word taken outside idle
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE)
    else $error("input taken while busy");

  // accepted word leaves idle
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted word dropped");

  // live count moves by at most one per word
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + 1'b1 ||
                      cnt_r == $past(cnt_r) - 1'b1))
    else $error("live count jumped");

  // ram writes only come from a write state
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r != S_IDLE && state_r != S_FIN)
    else $error("stray header write");
`endif

endmodule
